[rtl/core/tile_quad_generator_with_flips_macros.svh]
// assertion macros shared by the tile quad generator rtl
`ifndef TILE_QUAD_GENERATOR_WITH_FLIPS_MACROS_SVH
`define TILE_QUAD_GENERATOR_WITH_FLIPS_MACROS_SVH

// same-cycle implication, checked on every rising edge out of reset
`define TQG_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tqg assertion failed");

// next-cycle implication, checked on every rising edge out of reset
`define TQG_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tqg assertion failed");

`endif

[rtl/core/tqg_pkg.sv]
// types and constants of the tile quad generator
`timescale 1ns / 1ps

package tqg_pkg;

  localparam int CORNERS   = 4;
  localparam int CORNER_W  = 2;
  localparam int POS_W     = 17;
  localparam int TEX_W     = 13;
  localparam int REG_W     = 9;
  localparam int CFG_IDX_W = 2;

  localparam logic [POS_W-1:0]    POS_MAX     = '1;
  localparam logic [CORNER_W-1:0] LAST_CORNER = CORNER_W'(CORNERS - 1);
  localparam logic [REG_W-1:0]    REG_RESET   = REG_W'(16);

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT = CFG_IDX_W'(2);

  typedef struct packed {
    logic        layer_start;
    logic [15:0] tile_id;
    logic [11:0] image_x;
    logic [11:0] image_y;
    logic [8:0]  image_width;
    logic [8:0]  image_height;
    logic        flip_h;
    logic        flip_v;
    logic        flip_d;
  } tile_t;

  typedef struct packed {
    logic [CORNER_W-1:0] corner;
    logic [POS_W-1:0]    pos_x;
    logic [POS_W-1:0]    pos_y;
    logic [TEX_W-1:0]    tex_u;
    logic [TEX_W-1:0]    tex_v;
    logic                overflow;
    logic                last;
  } vertex_t;

endpackage

[rtl/core/tqg_if.sv]
// valid/ready channel interfaces for tile requests and vertex requests
`timescale 1ns / 1ps

interface tqg_tile_if import tqg_pkg::*; ();
  logic  valid;
  logic  ready;
  tile_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tqg_vertex_if import tqg_pkg::*; ();
  logic    valid;
  logic    ready;
  vertex_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/core/tile_quad_generator_with_flips.sv]
// tile quad generator: one tile request in, four flipped quad vertices out
// the first vertex is valid in the cycle after the tile request is accepted
// vertices leave the output port one per cycle while verts.ready is high;
//   the next tile is taken in the cycle the fourth vertex of the previous one leaves
// reset (rst, synchronous): counters, origins and overflow cleared, quad buffer
//   empty, all three registers back to 16
`timescale 1ns / 1ps
`include "tile_quad_generator_with_flips_macros.svh"

module tile_quad_generator_with_flips
  import tqg_pkg::*;
#(
  parameter int MAX_ROWS = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_wdata,
  tqg_tile_if.sink             tiles,
  tqg_vertex_if.source         verts
);

  // row counter just wide enough for MAX_ROWS - 1
  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam logic [ROW_W:0] ROW_LIMIT = (ROW_W + 1)'(MAX_ROWS);

  // register value 0 acts as 1, anything above 256 as 256
  function automatic logic [REG_W-1:0] clamp_reg(input logic [REG_W-1:0] r);
    logic [REG_W-1:0] c;
    c = r;
    if (r == '0) c = REG_W'(1);
    else if (r > REG_W'(256)) c = REG_W'(256);
    return c;
  endfunction

  // saturate an 18-bit position sum to the 17-bit screen range
  function automatic logic [POS_W-1:0] sat_pos(input logic [POS_W:0] s);
    return s[POS_W] ? POS_MAX : s[POS_W-1:0];
  endfunction

  // configuration registers
  logic [REG_W-1:0] map_width_tiles;
  logic [REG_W-1:0] tile_width_px;
  logic [REG_W-1:0] tile_height_px;

  // position state
  logic [7:0]       column_count, column_count_next;
  logic [ROW_W-1:0] row_count, row_count_next;
  logic [POS_W-1:0] origin_x, origin_x_next;
  logic [POS_W-1:0] origin_y, origin_y_next;
  logic             row_overflow, row_overflow_next;

  // quad buffer: four computed vertices waiting to leave
  logic                quad_valid;
  logic [CORNER_W-1:0] corner_cnt;
  logic [POS_W-1:0]    quad_px [CORNERS];
  logic [POS_W-1:0]    quad_py [CORNERS];
  logic [TEX_W-1:0]    quad_tu [CORNERS];
  logic [TEX_W-1:0]    quad_tv [CORNERS];
  logic                quad_ovf;

  // next quad from the incoming tile
  logic [POS_W-1:0] calc_px [CORNERS];
  logic [POS_W-1:0] calc_py [CORNERS];
  logic [TEX_W-1:0] calc_tu [CORNERS];
  logic [TEX_W-1:0] calc_tv [CORNERS];

  logic tile_fire, vert_fire, last_fire;

  assign vert_fire = verts.valid && verts.ready;
  assign last_fire = vert_fire && (corner_cnt == LAST_CORNER);
  // a new tile may enter while the previous quad hands off its final vertex
  assign tiles.ready = !quad_valid || last_fire;
  assign tile_fire = tiles.valid && tiles.ready;

  // layer_start clears the position before this tile is placed
  logic [7:0]       col_eff;
  logic [ROW_W-1:0] row_eff;
  logic [POS_W-1:0] ox_eff, oy_eff;
  logic             ovf_eff;

  assign col_eff = tiles.data.layer_start ? '0 : column_count;
  assign row_eff = tiles.data.layer_start ? '0 : row_count;
  assign ox_eff  = tiles.data.layer_start ? '0 : origin_x;
  assign oy_eff  = tiles.data.layer_start ? '0 : origin_y;
  assign ovf_eff = tiles.data.layer_start ? 1'b0 : row_overflow;

  // advance to the next map cell, wrapping at the row end
  logic [8:0]     col_inc;
  logic [ROW_W:0] row_inc;

  always_comb begin
    col_inc = {1'b0, col_eff} + 9'd1;
    row_inc = {1'b0, row_eff} + (ROW_W + 1)'(1);
    column_count_next = col_inc[7:0];
    row_count_next    = row_eff;
    origin_x_next     = sat_pos({1'b0, ox_eff} + (POS_W + 1)'(clamp_reg(tile_width_px)));
    origin_y_next     = oy_eff;
    row_overflow_next = ovf_eff;
    if (col_inc >= clamp_reg(map_width_tiles)) begin
      column_count_next = '0;
      origin_x_next     = '0;
      if (row_inc >= ROW_LIMIT) begin
        // row bound reached: hold the row and flag the rest of the layer
        row_overflow_next = 1'b1;
      end else begin
        row_count_next = row_inc[ROW_W-1:0];
        origin_y_next  = sat_pos({1'b0, oy_eff} + (POS_W + 1)'(clamp_reg(tile_height_px)));
      end
    end
  end

  // quad geometry and flipped texture coordinates
  logic [POS_W-1:0] px_lo, px_hi, py_lo, py_hi;
  logic [TEX_W-1:0] u_lo, u_hi, v_lo, v_hi, t_swap;
  logic             swap_u, swap_v;

  always_comb begin
    px_lo = ox_eff;
    px_hi = sat_pos({1'b0, ox_eff} + (POS_W + 1)'(tiles.data.image_width));
    py_lo = oy_eff;
    py_hi = sat_pos({1'b0, oy_eff} + (POS_W + 1)'(tiles.data.image_height));
    if (ovf_eff) begin
      px_lo = POS_MAX;
      px_hi = POS_MAX;
      py_lo = POS_MAX;
      py_hi = POS_MAX;
    end

    u_lo = TEX_W'(tiles.data.image_x);
    u_hi = TEX_W'(tiles.data.image_x) + TEX_W'(tiles.data.image_width);
    v_lo = TEX_W'(tiles.data.image_y);
    v_hi = TEX_W'(tiles.data.image_y) + TEX_W'(tiles.data.image_height);

    // with the diagonal flag the h and v flags trade axes
    swap_u = tiles.data.flip_d ? tiles.data.flip_v : tiles.data.flip_h;
    swap_v = tiles.data.flip_d ? tiles.data.flip_h : tiles.data.flip_v;

    calc_px[0] = px_lo;  calc_py[0] = py_lo;
    calc_px[1] = px_hi;  calc_py[1] = py_lo;
    calc_px[2] = px_hi;  calc_py[2] = py_hi;
    calc_px[3] = px_lo;  calc_py[3] = py_hi;

    calc_tu[0] = swap_u ? u_hi : u_lo;
    calc_tu[1] = swap_u ? u_lo : u_hi;
    calc_tu[2] = swap_u ? u_lo : u_hi;
    calc_tu[3] = swap_u ? u_hi : u_lo;
    calc_tv[0] = swap_v ? v_hi : v_lo;
    calc_tv[1] = swap_v ? v_hi : v_lo;
    calc_tv[2] = swap_v ? v_lo : v_hi;
    calc_tv[3] = swap_v ? v_lo : v_hi;

    // diagonal flip exchanges the texture corners top-right and bottom-left
    if (tiles.data.flip_d) begin
      t_swap     = calc_tu[1];
      calc_tu[1] = calc_tu[3];
      calc_tu[3] = t_swap;
      t_swap     = calc_tv[1];
      calc_tv[1] = calc_tv[3];
      calc_tv[3] = t_swap;
    end else begin
      t_swap = '0;
    end

    // transparent tile: all-zero vertices
    if (tiles.data.tile_id == '0) begin
      for (int k = 0; k < CORNERS; k++) begin
        calc_px[k] = '0;
        calc_py[k] = '0;
        calc_tu[k] = '0;
        calc_tv[k] = '0;
      end
    end
  end

  // configuration writes, indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      map_width_tiles <= REG_RESET;
      tile_width_px   <= REG_RESET;
      tile_height_px  <= REG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAP_WIDTH:   map_width_tiles <= cfg_wdata;
        REG_TILE_WIDTH:  tile_width_px   <= cfg_wdata;
        REG_TILE_HEIGHT: tile_height_px  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // position state moves once per accepted tile
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      origin_x     <= '0;
      origin_y     <= '0;
      row_overflow <= 1'b0;
    end else if (tile_fire) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      origin_x     <= origin_x_next;
      origin_y     <= origin_y_next;
      row_overflow <= row_overflow_next;
    end
  end

  // quad buffer control: fill on a tile request, drain one corner per vertex request
  always_ff @(posedge clk) begin
    if (rst) begin
      quad_valid <= 1'b0;
      corner_cnt <= '0;
    end else begin
      if (vert_fire) corner_cnt <= corner_cnt + CORNER_W'(1);
      if (tile_fire) quad_valid <= 1'b1;
      else if (last_fire) quad_valid <= 1'b0;
    end
  end

  // quad payload, no reset needed
  always_ff @(posedge clk) begin
    if (tile_fire) begin
      quad_px  <= calc_px;
      quad_py  <= calc_py;
      quad_tu  <= calc_tu;
      quad_tv  <= calc_tv;
      quad_ovf <= ovf_eff;
    end
  end

  // vertex request out of the buffer
  assign verts.valid         = quad_valid;
  assign verts.data.corner   = corner_cnt;
  assign verts.data.pos_x    = quad_px[corner_cnt];
  assign verts.data.pos_y    = quad_py[corner_cnt];
  assign verts.data.tex_u    = quad_tu[corner_cnt];
  assign verts.data.tex_v    = quad_tv[corner_cnt];
  assign verts.data.overflow = quad_ovf;
  assign verts.data.last     = (corner_cnt == LAST_CORNER);

  // a loaded quad always starts at the top-left corner
  `TQG_ASSERT_NEXT(a_load_starts_tl, clk, rst, tile_fire, quad_valid && corner_cnt == '0)
  // a quad never drops out before its last corner is taken
  `TQG_ASSERT_NEXT(a_no_early_drop, clk, rst, vert_fire && corner_cnt != LAST_CORNER, quad_valid)
  // a tile is taken over a full buffer only when its last vertex leaves
  `TQG_ASSERT_NOW(a_take_on_last, clk, rst, tiles.ready && quad_valid, last_fire)
  // the buffer empties after the last corner when no tile follows
  `TQG_ASSERT_NEXT(a_empty_after_last, clk, rst, last_fire && !tile_fire, !quad_valid)

endmodule
